// ----- rtl/bprg_pkg.sv -----
// Shared types and constants for the byte pool random generator.
// Used by byte_pool_random_generator_core and its testbench.
package bprg_pkg;

    // pool size must stay a power of two: pool indexes wrap by truncation
    localparam int POOL_BYTES = 256;
    localparam int POOL_AW    = $clog2(POOL_BYTES);
    localparam int FILL_W     = POOL_AW + 1;
    localparam int MAX_RUN    = 64;
    localparam int RUN_W      = 7;
    localparam int MIX_TAP    = 7;
    localparam int WORD_W     = 32;
    localparam int DRAW_BYTES = 4;
    localparam int BIT_W      = $clog2(WORD_W);

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [1:0] {
        REQ_SEED  = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_DRAW  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_NOT_READY = 2'd1,
        ERR_BAD_RANGE = 2'd2
    } err_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_MIX,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/byte_pool_random_generator_core.sv -----
// Byte pool random generator, top level.
// Depends on bprg_pkg and bprg_ram.
//
// Usage:
//   s_ channel takes requests: tuser is the request kind (seed byte, byte run,
//   range draw), tdata carries seed byte, byte count and range bounds.
//   m_ channel returns results: tdata holds the random byte and range word,
//   tuser the error code, tlast marks the final result of a request.
//   256 seed requests fill the pool; a seed after a full load restarts filling
//   at entry 0 and the pool is not ready until it is full again.
//   A seed is written straight from idle. A byte run takes, per byte, three
//   reads through the single pool read port, one mix/write and one emit. A range
//   draw first computes the rejection threshold, then draws words of four pool
//   bytes until one passes, then the final modulo; threshold and modulo share
//   one bit-serial remainder unit. Error results go straight to the emit step.
//   One request is processed at a time; s_tready is high only when idle. The
//   last result sits in an output register, so a new request is taken while it
//   waits. A stalled receiver holds the sequencer at its emit step.
//   Reset clears fill count and control; pool contents are kept.
module byte_pool_random_generator_core
    import bprg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] seed_value, [14:8] byte_count, [46:15] range_low,
    // [78:47] range_high, [79] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] rand_byte, [39:8] rand_word
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    // [1:0] err_code
    output logic [1:0]            m_tuser
);

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [RUN_W-1:0]    idx_reg, idx_next;
    logic [RUN_W-1:0]    cnt_reg, cnt_next;
    logic                draw_reg, draw_next;     // request is a range draw
    logic                first_reg, first_next;   // first word of a draw
    logic                thr_phase_reg, thr_phase_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic [WORD_W-1:0]   span_reg, span_next;
    logic [WORD_W-1:0]   thr_reg, thr_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [WORD_W-1:0]   start_reg, start_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   dvd_reg, dvd_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [7:0]          a_reg, a_next;
    logic [7:0]          b_reg, b_next;
    logic [7:0]          res_byte_reg, res_byte_next;
    logic [WORD_W-1:0]   res_word_reg, res_word_next;
    logic                res_last_reg, res_last_next;
    logic [1:0]          res_err_reg, res_err_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic [1:0]          m_user_reg, m_user_next;

    logic                ram_we;
    logic [POOL_AW-1:0]  ram_waddr;
    logic [7:0]          ram_wdata;
    logic [POOL_AW-1:0]  ram_raddr;
    logic [7:0]          ram_rdata;

    logic                pool_ready;
    logic                s_fire;
    logic [6:0]          in_count;
    logic [WORD_W-1:0]   in_lo, in_hi, in_span;
    logic                bad_range;
    logic [7:0]          mixed;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     trial_sub;
    logic                out_free;
    logic [1:0]          byte_sel;

    bprg_ram #(
        .WIDTH (8),
        .DEPTH (POOL_BYTES)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pool_ready = (fill_reg == FILL_W'(POOL_BYTES));
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign in_count   = s_tdata[14:8];
    assign in_lo      = s_tdata[46:15];
    assign in_hi      = s_tdata[78:47];
    assign in_span    = in_hi - in_lo;
    assign bad_range  = (in_lo >= in_hi) || (in_span == {WORD_W{1'b1}});
    assign mixed      = a_reg ^ (b_reg + ram_rdata);
    assign trial      = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial_sub  = trial - {1'b0, span_reg};
    assign out_free   = !m_valid_reg || m_tready;
    assign byte_sel   = idx_reg[1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        draw_reg      <= draw_next;
        first_reg     <= first_next;
        thr_phase_reg <= thr_phase_next;
        lo_reg        <= lo_next;
        span_reg      <= span_next;
        thr_reg       <= thr_next;
        word_reg      <= word_next;
        start_reg     <= start_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        bit_reg       <= bit_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_byte_reg  <= res_byte_next;
        res_word_reg  <= res_word_next;
        res_last_reg  <= res_last_next;
        res_err_reg   <= res_err_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_user_reg    <= m_user_next;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        draw_next      = draw_reg;
        first_next     = first_reg;
        thr_phase_next = thr_phase_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        thr_next       = thr_reg;
        word_next      = word_reg;
        start_next     = start_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        bit_next       = bit_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_byte_next  = res_byte_reg;
        res_word_next  = res_word_reg;
        res_last_next  = res_last_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        ram_we         = 1'b0;
        ram_waddr      = POOL_AW'(idx_reg);
        ram_wdata      = mixed;
        ram_raddr      = POOL_AW'(idx_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                idx_next      = '0;
                first_next    = 1'b1;
                res_byte_next = '0;
                res_word_next = '0;
                res_last_next = 1'b1;
                res_err_next  = ERR_OK;
                if (s_fire) begin
                    case (req_type_t'(s_tuser))
                        REQ_SEED: begin
                            ram_we    = 1'b1;
                            ram_wdata = s_tdata[7:0];
                            if (pool_ready) begin
                                ram_waddr = '0;
                                fill_next = FILL_W'(1);
                            end else begin
                                ram_waddr = fill_reg[POOL_AW-1:0];
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        REQ_RUN: begin
                            draw_next = 1'b0;
                            cnt_next  = (in_count > RUN_W'(MAX_RUN)) ?
                                        RUN_W'(MAX_RUN) : in_count;
                            if (!pool_ready) begin
                                res_err_next = ERR_NOT_READY;
                                state_next   = ST_EMIT;
                            end else if (in_count != '0) begin
                                state_next = ST_RD_A;
                            end
                        end
                        REQ_DRAW: begin
                            draw_next = 1'b1;
                            lo_next   = in_lo;
                            span_next = in_span;
                            if (bad_range) begin
                                res_err_next = ERR_BAD_RANGE;
                                state_next   = ST_EMIT;
                            end else if (!pool_ready) begin
                                res_err_next = ERR_NOT_READY;
                                state_next   = ST_EMIT;
                            end else begin
                                // threshold = (2^32 - span) mod span
                                dvd_next       = '0 - in_span;
                                rem_next       = '0;
                                bit_next       = '0;
                                thr_phase_next = 1'b1;
                                state_next     = ST_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_RD_A: begin
                ram_raddr  = POOL_AW'(idx_reg);
                state_next = ST_RD_B;
            end

            ST_RD_B: begin
                ram_raddr  = POOL_AW'(idx_reg) + POOL_AW'(1);
                a_next     = ram_rdata;
                state_next = ST_RD_C;
            end

            ST_RD_C: begin
                ram_raddr  = POOL_AW'(idx_reg) + POOL_AW'(MIX_TAP);
                b_next     = ram_rdata;
                state_next = ST_MIX;
            end

            ST_MIX: begin
                ram_we    = 1'b1;
                ram_waddr = POOL_AW'(idx_reg);
                ram_wdata = mixed;
                if (!draw_reg) begin
                    res_byte_next = mixed;
                    res_last_next = (idx_reg + RUN_W'(1) == cnt_reg);
                    state_next    = ST_EMIT;
                end else begin
                    word_next[8*byte_sel +: 8] = mixed;
                    // entry i is still untouched when step i reads it
                    if (first_reg) begin
                        start_next[8*byte_sel +: 8] = a_reg;
                    end
                    if (idx_reg == RUN_W'(DRAW_BYTES - 1)) begin
                        state_next = ST_CHECK;
                    end else begin
                        idx_next   = idx_reg + RUN_W'(1);
                        state_next = ST_RD_A;
                    end
                end
            end

            ST_CHECK: begin
                first_next = 1'b0;
                idx_next   = '0;
                // a word back at the starting bytes ends the rejection cycle
                if (word_reg >= thr_reg || word_reg == start_reg) begin
                    dvd_next       = word_reg;
                    rem_next       = '0;
                    bit_next       = '0;
                    thr_phase_next = 1'b0;
                    state_next     = ST_DIV;
                end else begin
                    state_next = ST_RD_A;
                end
            end

            ST_DIV: begin
                // restoring remainder, one dividend bit per cycle
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
                bit_next = bit_reg + BIT_W'(1);
                if (!trial_sub[WORD_W]) begin
                    rem_next = trial_sub[WORD_W-1:0];
                end else begin
                    rem_next = trial[WORD_W-1:0];
                end
                if (bit_reg == BIT_W'(WORD_W - 1)) begin
                    if (thr_phase_reg) begin
                        thr_next   = rem_next;
                        idx_next   = '0;
                        first_next = 1'b1;
                        state_next = ST_RD_A;
                    end else begin
                        res_word_next = lo_reg + rem_next;
                        res_last_next = 1'b1;
                        state_next    = ST_EMIT;
                    end
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_word_reg, res_byte_reg};
                    m_last_next  = res_last_reg;
                    m_user_next  = res_err_reg;
                    if (res_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + RUN_W'(1);
                        state_next = ST_RD_A;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bprg_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bprg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
